FILE: rtl/bsd_pkg.sv
// Shared types, constants and width helpers for the binomial segmentation unit.
`default_nettype none
package bsd_pkg;

   localparam int DEF_MAX_WINDOW = 64;
   localparam int DEF_NUM_DSETS  = 4;

   localparam int LEN_W      = 7;
   localparam int SCORE_W    = 48;
   localparam int ACC_W      = 50;
   localparam int LOG_FRAC_W = 16;
   localparam int LOG_E_W    = 5;
   localparam int LOG_W      = LOG_E_W + LOG_FRAC_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_GAP      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PSEUDO_COUNT = 2'd2;

   localparam logic [6:0]  RST_WINDOW_LIMIT = 7'd64;
   localparam logic [31:0] RST_MAX_GAP      = 32'd0;
   localparam logic [15:0] RST_PSEUDO_COUNT = 16'd256;

   localparam logic signed [SCORE_W-1:0] SCORE_NEG_INF = {1'b1, {(SCORE_W-1){1'b0}}};
   localparam logic signed [SCORE_W-1:0] SCORE_MAX     = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam logic signed [SCORE_W-1:0] SCORE_MIN     = {1'b1, {(SCORE_W-2){1'b0}}, 1'b1};

   // per-dataset running sum width for a window of w sites
   function automatic int sum_width(input int w);
      return $clog2(255 * w + 1);
   endfunction

   // width of one lane's signed score
   function automatic int lane_width(input int w);
      return sum_width(w) + LOG_W + 3;
   endfunction

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_PLACE,
      ST_READ,
      ST_LOAD,
      ST_EVAL,
      ST_SUM,
      ST_MERGE,
      ST_FINISH
   } top_state_type;

   typedef enum logic [2:0] {
      LN_IDLE,
      LN_START,
      LN_RUN,
      LN_DIFF,
      LN_MUL,
      LN_DONE
   } lane_state_type;

   typedef struct packed {
      logic read;
      logic load;
      logic fresh;
   } lane_ctrl_type;

endpackage
`default_nettype wire

FILE: rtl/bsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/bsd_log2.sv
// Iterative log2 in Q.16: normalize, then one squaring per fraction bit.
`default_nettype none
module bsd_log2 import bsd_pkg::*; #(
   parameter int X_W = 23
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [X_W-1:0]   x,
   output logic                  busy,
   output logic      [LOG_W-1:0] result
);

   logic [31:0]            y_ff;
   logic [LOG_E_W-1:0]     e_ff;
   logic [LOG_FRAC_W-1:0]  frac_ff;
   logic [4:0]             cnt_ff;

   logic [LOG_E_W-1:0]     e_lead;
   logic [31:0]            y_norm;
   logic [63:0]            sq;
   logic [32:0]            sq_top;

   always_comb begin
      e_lead = '0;
      for (int i = 0; i < X_W; i++) begin
         if (x[i]) e_lead = LOG_E_W'(i);
      end
      y_norm = 32'(x) << (LOG_E_W'(31) - e_lead);
      sq     = 64'(y_ff) * 64'(y_ff);
      sq_top = sq[63:31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= 5'(LOG_FRAC_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         y_ff    <= y_norm;
         e_ff    <= e_lead;
         frac_ff <= '0;
      end else if (cnt_ff != '0) begin
         if (sq_top[32]) begin
            y_ff    <= sq_top[32:1];
            frac_ff <= {frac_ff[LOG_FRAC_W-2:0], 1'b1};
         end else begin
            y_ff    <= sq_top[31:0];
            frac_ff <= {frac_ff[LOG_FRAC_W-2:0], 1'b0};
         end
      end
   end

   assign busy   = (cnt_ff != '0);
   assign result = {e_ff, frac_ff};

endmodule
`default_nettype wire

FILE: rtl/bsd_lane.sv
// One dataset lane: owns its running sums and scores one cell's block.
`default_nettype none
module bsd_lane import bsd_pkg::*; #(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   localparam int ADDR_W = $clog2(MAX_WINDOW),
   localparam int LANE_W = lane_width(MAX_WINDOW)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lane_ctrl_type            ctrl,
   input  wire logic [ADDR_W-1:0]        addr,
   input  wire logic [7:0]               site_meth,
   input  wire logic [7:0]               site_total,
   input  wire logic [15:0]              pseudo,
   output logic                          done,
   output logic signed [LANE_W-1:0]      score
);

   localparam int SUM_W  = sum_width(MAX_WINDOW);
   localparam int X_W    = SUM_W + 9;
   localparam int PROD_W = SUM_W + LOG_W + 2;

   lane_state_type state_ff, state_in;

   logic [2*SUM_W-1:0] rdata;
   logic [SUM_W-1:0]   m_old, t_old, m_new, t_new;
   logic [X_W-1:0]     a_in, b_in;
   logic               ram_we, log_start;

   logic [SUM_W-1:0]   m_ff, t_ff;
   logic [X_W-1:0]     a_ff, b_ff, c_ff;
   logic signed [LOG_W:0] da_ff, dc_ff;
   logic signed [LANE_W-1:0] score_ff;

   logic [LOG_W-1:0]   la, lb, lc;
   logic               busy_a, busy_b, busy_c;

   logic signed [SUM_W:0]    m_s, r_s;
   logic signed [PROD_W-1:0] p1, p2;

   bsd_ram #(.WIDTH(2*SUM_W), .DEPTH(MAX_WINDOW)) u_sums (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr),
      .wr_data ({m_new, t_new}),
      .rd_en   (ctrl.read),
      .rd_addr (addr),
      .rd_data (rdata)
   );

   always_comb begin
      m_old = ctrl.fresh ? '0 : rdata[2*SUM_W-1:SUM_W];
      t_old = ctrl.fresh ? '0 : rdata[SUM_W-1:0];
      m_new = m_old + SUM_W'(site_meth);
      t_new = t_old + SUM_W'(site_total);
      a_in  = {1'b0, m_new, 8'd0} + X_W'(pseudo);
      b_in  = {1'b0, t_new, 8'd0} + X_W'({pseudo, 1'b0});
   end

   bsd_log2 #(.X_W(X_W)) u_log_a (
      .clock(clock), .reset(reset), .start(log_start), .x(a_ff), .busy(busy_a), .result(la)
   );
   bsd_log2 #(.X_W(X_W)) u_log_b (
      .clock(clock), .reset(reset), .start(log_start), .x(b_ff), .busy(busy_b), .result(lb)
   );
   bsd_log2 #(.X_W(X_W)) u_log_c (
      .clock(clock), .reset(reset), .start(log_start), .x(c_ff), .busy(busy_c), .result(lc)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         LN_IDLE:  if (ctrl.load) state_in = LN_START;
         LN_START: state_in = LN_RUN;
         LN_RUN:   if (!(busy_a || busy_b || busy_c)) state_in = LN_DIFF;
         LN_DIFF:  state_in = LN_MUL;
         LN_MUL:   state_in = LN_DONE;
         LN_DONE:  state_in = LN_IDLE;
         default:  state_in = LN_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ram_we    = (state_ff == LN_IDLE) && ctrl.load;
      log_start = (state_ff == LN_START);
      done      = (state_ff == LN_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LN_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      m_s = {1'b0, m_ff};
      r_s = {1'b0, t_ff - m_ff};
      p1  = m_s * da_ff;
      p2  = r_s * dc_ff;
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         m_ff <= m_new;
         t_ff <= t_new;
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= b_in - a_in;
      end
      if (state_ff == LN_DIFF) begin
         da_ff <= $signed({1'b0, la}) - $signed({1'b0, lb});
         dc_ff <= $signed({1'b0, lc}) - $signed({1'b0, lb});
      end
      if (state_ff == LN_MUL) begin
         score_ff <= LANE_W'(p1) + LANE_W'(p2);
      end
   end

   assign score = score_ff;

endmodule
`default_nettype wire

FILE: rtl/binomial_segmentation_dp_unit.sv
// Top level: site intake, cell window control, dataset lanes and best-block merge.
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/ready   | restart, position, meth/total byte counts
//  rsp     | out       | rsp_valid/ready   | segment_length, total_score, bad_counts
//  csr     | in        | csr_wr_en only    | csr_index, csr_wdata (no read-back)
//
// Sequence: each site is set up and placed in the window, then each live cell
//   costs one pass through the lanes: read, load, lane evaluation (the 16-step
//   squaring loop of the log2 units), sum and merge.
// Reset: synchronous; empties the window, zeroes the carried prior score and
//   loads the register defaults. Cell memories need no clearing pass.
// Stalls: the result sits in an output register; a new site is accepted while
//   it waits. A result that finds the register still full holds until rsp_ready.
`default_nettype none
module binomial_segmentation_dp_unit import bsd_pkg::*; #(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int NUM_DSETS  = DEF_NUM_DSETS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_restart,
   input  wire logic [31:0]                  req_position,
   input  wire logic [31:0]                  req_meth_counts,
   input  wire logic [31:0]                  req_total_counts,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [LEN_W-1:0]                  rsp_segment_length,
   output logic signed [SCORE_W-1:0]         rsp_total_score,
   output logic                              rsp_bad_counts,
   input  wire logic                         csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]         csr_index,
   input  wire logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_WINDOW);
   localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int LANE_W = lane_width(MAX_WINDOW);

   // configuration
   logic [6:0]  window_limit_ff;
   logic [31:0] max_gap_ff;
   logic [15:0] pseudo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_limit_ff <= RST_WINDOW_LIMIT;
         max_gap_ff      <= RST_MAX_GAP;
         pseudo_ff       <= RST_PSEUDO_COUNT;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WINDOW_LIMIT: window_limit_ff <= csr_wdata[6:0];
            CSR_MAX_GAP:      max_gap_ff      <= csr_wdata;
            CSR_PSEUDO_COUNT: pseudo_ff       <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // state
   top_state_type state_ff, state_in;

   logic [ADDR_W-1:0]        head_ff;       // oldest live cell
   logic [CNT_W-1:0]         live_ff;
   logic [CNT_W-1:0]         c_ff;          // cell under evaluation, oldest first
   logic signed [SCORE_W-1:0] next_prior_ff;
   logic signed [SCORE_W-1:0] best_ff;
   logic [CNT_W-1:0]         best_len_ff;

   logic                     restart_ff;
   logic [31:0]              pos_ff;
   logic [7:0]               site_m_ff [NUM_DSETS];
   logic [7:0]               site_t_ff [NUM_DSETS];
   logic                     bad_ff;

   logic signed [SCORE_W-1:0] prior_ff;
   logic                     inf_ff;
   logic signed [ACC_W-1:0]  blocksum_ff;

   logic                     rsp_valid_ff;
   logic [LEN_W-1:0]         rsp_len_ff;
   logic signed [SCORE_W-1:0] rsp_score_ff;
   logic                     rsp_bad_ff;

   // handshake
   logic req_fire, rsp_free, rsp_load;
   assign req_fire = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_load = (state_ff == ST_FINISH) && rsp_free;

   // site unpacking: bytes above the 32-bit word read as zero; clamp meth to total
   logic [7:0] site_m_in [NUM_DSETS];
   logic [7:0] site_t_in [NUM_DSETS];
   logic       bad_in;

   always_comb begin
      bad_in = 1'b0;
      for (int d = 0; d < NUM_DSETS; d++) begin
         site_m_in[d] = 8'(req_meth_counts >> (8 * d));
         site_t_in[d] = 8'(req_total_counts >> (8 * d));
         if (site_m_in[d] > site_t_in[d]) begin
            site_m_in[d] = site_t_in[d];
            bad_in       = 1'b1;
         end
      end
   end

   // window bookkeeping
   logic [CNT_W-1:0]  limit;
   logic [CNT_W-1:0]  n0, drop;
   logic [CNT_W:0]    head_sum, new_sum, cur_sum;
   logic [ADDR_W-1:0] head_in, new_addr, cur_addr;

   always_comb begin
      if (window_limit_ff == 7'd0) begin
         limit = CNT_W'(1);
      end else if (int'(window_limit_ff) > MAX_WINDOW) begin
         limit = CNT_W'(MAX_WINDOW);
      end else begin
         limit = CNT_W'(window_limit_ff);
      end

      n0       = restart_ff ? '0 : live_ff;
      drop     = (n0 >= limit) ? (n0 - (limit - CNT_W'(1))) : '0;
      head_sum = (CNT_W+1)'(head_ff) + (CNT_W+1)'(drop);
      if (head_sum >= (CNT_W+1)'(MAX_WINDOW)) head_sum = head_sum - (CNT_W+1)'(MAX_WINDOW);
      head_in  = ADDR_W'(head_sum);

      // new cell goes right after the newest live one
      new_sum = (CNT_W+1)'(head_ff) + (CNT_W+1)'(live_ff);
      if (new_sum >= (CNT_W+1)'(MAX_WINDOW)) new_sum = new_sum - (CNT_W+1)'(MAX_WINDOW);
      new_addr = ADDR_W'(new_sum);

      cur_sum = (CNT_W+1)'(head_ff) + (CNT_W+1)'(c_ff);
      if (cur_sum >= (CNT_W+1)'(MAX_WINDOW)) cur_sum = cur_sum - (CNT_W+1)'(MAX_WINDOW);
      cur_addr = ADDR_W'(cur_sum);
   end

   // cell position and prior score memories
   logic        cell_we, cell_re;
   logic [31:0] cell_pos_rd;
   logic [SCORE_W-1:0] cell_prior_rd;

   bsd_ram #(.WIDTH(32), .DEPTH(MAX_WINDOW)) u_cell_pos (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (new_addr),
      .wr_data (pos_ff),
      .rd_en   (cell_re),
      .rd_addr (cur_addr),
      .rd_data (cell_pos_rd)
   );

   bsd_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_WINDOW)) u_cell_prior (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (new_addr),
      .wr_data (next_prior_ff),
      .rd_en   (cell_re),
      .rd_addr (cur_addr),
      .rd_data (cell_prior_rd)
   );

   // dataset lanes
   lane_ctrl_type            lane_ctrl;
   logic [NUM_DSETS-1:0]     lane_done;
   logic signed [LANE_W-1:0] lane_score [NUM_DSETS];

   for (genvar d = 0; d < NUM_DSETS; d++) begin : g_lane
      bsd_lane #(.MAX_WINDOW(MAX_WINDOW)) u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (lane_ctrl),
         .addr       (cur_addr),
         .site_meth  (site_m_ff[d]),
         .site_total (site_t_ff[d]),
         .pseudo     (pseudo_ff),
         .done       (lane_done[d]),
         .score      (lane_score[d])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_SETUP;
         ST_SETUP:  state_in = ST_PLACE;
         ST_PLACE:  state_in = ST_READ;
         ST_READ:   state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_EVAL;
         ST_EVAL:   if (&lane_done) state_in = ST_SUM;
         ST_SUM:    state_in = ST_MERGE;
         ST_MERGE:  state_in = (c_ff + CNT_W'(1) == live_ff) ? ST_FINISH : ST_READ;
         ST_FINISH: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready       = (state_ff == ST_IDLE);
      cell_we         = (state_ff == ST_PLACE);
      cell_re         = (state_ff == ST_READ);
      lane_ctrl.read  = (state_ff == ST_READ);
      lane_ctrl.load  = (state_ff == ST_LOAD);
      lane_ctrl.fresh = (c_ff == live_ff - CNT_W'(1));
   end

   // gap check and merge arithmetic
   logic                    gap_bad;
   logic signed [ACC_W-1:0] lane_sum, total_raw;
   logic signed [SCORE_W-1:0] total;

   always_comb begin
      gap_bad = (max_gap_ff != 32'd0) &&
                ((pos_ff < cell_pos_rd) || ((pos_ff - cell_pos_rd) > max_gap_ff));

      lane_sum = '0;
      for (int d = 0; d < NUM_DSETS; d++) begin
         lane_sum = lane_sum + ACC_W'(lane_score[d]);
      end

      total_raw = ACC_W'(prior_ff) + blocksum_ff;
      if (inf_ff) begin
         total = SCORE_NEG_INF;
      end else if (total_raw > ACC_W'(SCORE_MAX)) begin
         total = SCORE_MAX;
      end else if (total_raw < ACC_W'(SCORE_MIN)) begin
         total = SCORE_MIN;
      end else begin
         total = SCORE_W'(total_raw);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         live_ff       <= '0;
         c_ff          <= '0;
         next_prior_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_SETUP: begin
               head_ff <= head_in;
               live_ff <= (n0 >= limit) ? (limit - CNT_W'(1)) : n0;
               if (restart_ff) next_prior_ff <= '0;
            end
            ST_PLACE: begin
               live_ff <= live_ff + CNT_W'(1);
               c_ff    <= '0;
            end
            ST_MERGE: c_ff <= c_ff + CNT_W'(1);
            ST_FINISH: if (rsp_free) next_prior_ff <= best_ff;
            default: ;
         endcase
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         restart_ff <= req_restart;
         pos_ff     <= req_position;
         bad_ff     <= bad_in;
         for (int d = 0; d < NUM_DSETS; d++) begin
            site_m_ff[d] <= site_m_in[d];
            site_t_ff[d] <= site_t_in[d];
         end
      end
      if (state_ff == ST_PLACE) begin
         best_ff     <= SCORE_NEG_INF;
         best_len_ff <= '0;
      end
      if (state_ff == ST_LOAD) begin
         prior_ff <= cell_prior_rd;
         inf_ff   <= gap_bad || (cell_prior_rd == SCORE_NEG_INF);
      end
      if (state_ff == ST_SUM) begin
         blocksum_ff <= lane_sum;
      end
      // strict compare: the oldest start keeps a tie
      if ((state_ff == ST_MERGE) && (total > best_ff)) begin
         best_ff     <= total;
         best_len_ff <= live_ff - c_ff;
      end
      if (rsp_load) begin
         rsp_len_ff   <= LEN_W'(best_len_ff);
         rsp_score_ff <= best_ff;
         rsp_bad_ff   <= bad_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_segment_length = rsp_len_ff;
   assign rsp_total_score    = rsp_score_ff;
   assign rsp_bad_counts     = rsp_bad_ff;

endmodule
`default_nettype wire
